// ===== src/phc_pkg.sv =====
package phc_pkg;

  localparam int DELTA_W = 12;
  localparam int TICKS_W = 20;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic [TICKS_W-1:0] ticks_t;

  typedef enum logic [1:0] {
    FUNC_FLOW = 2'd0,
    FUNC_TEMP = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACT_NONE        = 2'd0,
    ACT_ON          = 2'd1,
    ACT_OFF_TEMP    = 2'd2,
    ACT_OFF_TIMEOUT = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_THRESHOLD  = 3'd0,
    REG_OFF_THRESHOLD = 3'd1,
    REG_MIN_OFF_TICKS = 3'd2,
    REG_MIN_ON_TICKS  = 3'd3,
    REG_MAX_ON_TICKS  = 3'd4
  } cfg_reg_t;

  localparam delta_t ON_THRESHOLD_RST  = 12'sd96;
  localparam delta_t OFF_THRESHOLD_RST = 12'sd48;
  localparam ticks_t MIN_OFF_TICKS_RST = 20'd180000;
  localparam ticks_t MIN_ON_TICKS_RST  = 20'd60000;
  localparam ticks_t MAX_ON_TICKS_RST  = 20'd600000;

endpackage

// ===== src/pump_hysteresis_controller.sv =====
// Channel  Direction  Handshake            Payload
// in       into block in_valid / in_stall  func, temp_delta
// out      from block out_valid / out_stall pump_on, action
// cfg      into block cfg_wr_en            cfg_index, cfg_data
//
// Result path: the input register loads at the input transfer, then the decision
// logic (compares and the time counter) writes the result register once the
// output side can advance.
// One item per cycle sustained while out is not stalled; the input register can still fill while the result is held.
// Reset clears relay, counter, flags and loads the default thresholds and tick limits.
// A stall on a valid out result holds the result stage and raises in_stall once the input stage is full.
module pump_hysteresis_controller #(
  parameter int TIME_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         func,
  input  logic signed [phc_pkg::DELTA_W-1:0] temp_delta,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               pump_on,
  output logic [1:0]                         action,
  input  logic                               cfg_wr_en,
  input  logic [phc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [phc_pkg::TICKS_W-1:0]        cfg_data
);

  localparam int CMP_W = (TIME_BITS > phc_pkg::TICKS_W) ? TIME_BITS : phc_pkg::TICKS_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  phc_pkg::delta_t on_threshold;
  phc_pkg::delta_t off_threshold;
  phc_pkg::ticks_t min_off_ticks;
  phc_pkg::ticks_t min_on_ticks;
  phc_pkg::ticks_t max_on_ticks;

  logic                 pump_running;
  logic [TIME_BITS-1:0] time_in_state;
  logic                 ever_switched;
  phc_pkg::delta_t      latest_delta;

  logic                 s1_valid;
  phc_pkg::func_t       s1_func;
  phc_pkg::delta_t      s1_delta;

  logic                 advance;
  logic                 s1_fire;

  logic                 pump_running_next;
  logic [TIME_BITS-1:0] time_in_state_next;
  logic                 ever_switched_next;
  phc_pkg::delta_t      latest_delta_next;
  phc_pkg::action_t     action_next;

  logic [TIME_BITS-1:0] time_inc;
  logic [CMP_W-1:0]     time_cmp;
  logic [CMP_W-1:0]     time_inc_cmp;

  assign advance  = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  assign time_inc     = (time_in_state == TIME_MAX) ? time_in_state : time_in_state + 1'b1;
  assign time_cmp     = CMP_W'(time_in_state);
  assign time_inc_cmp = CMP_W'(time_inc);

  always_comb begin
    pump_running_next  = pump_running;
    time_in_state_next = time_in_state;
    ever_switched_next = ever_switched;
    latest_delta_next  = latest_delta;
    action_next        = phc_pkg::ACT_NONE;
    case (s1_func)
      phc_pkg::FUNC_FLOW: begin
        if (latest_delta >= on_threshold && !pump_running &&
            (time_cmp >= CMP_W'(min_off_ticks) || !ever_switched)) begin
          pump_running_next  = 1'b1;
          time_in_state_next = '0;
          ever_switched_next = 1'b1;
          action_next        = phc_pkg::ACT_ON;
        end
      end
      phc_pkg::FUNC_TEMP: begin
        latest_delta_next = s1_delta;
        if (s1_delta <= off_threshold && pump_running &&
            time_cmp >= CMP_W'(min_on_ticks)) begin
          pump_running_next  = 1'b0;
          time_in_state_next = '0;
          ever_switched_next = 1'b1;
          action_next        = phc_pkg::ACT_OFF_TEMP;
        end
      end
      phc_pkg::FUNC_TICK: begin
        time_in_state_next = time_inc;
        if (pump_running && time_inc_cmp >= CMP_W'(max_on_ticks)) begin
          pump_running_next  = 1'b0;
          time_in_state_next = '0;
          ever_switched_next = 1'b1;
          action_next        = phc_pkg::ACT_OFF_TIMEOUT;
        end
      end
      default: begin
        action_next = phc_pkg::ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_threshold  <= phc_pkg::ON_THRESHOLD_RST;
      off_threshold <= phc_pkg::OFF_THRESHOLD_RST;
      min_off_ticks <= phc_pkg::MIN_OFF_TICKS_RST;
      min_on_ticks  <= phc_pkg::MIN_ON_TICKS_RST;
      max_on_ticks  <= phc_pkg::MAX_ON_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (phc_pkg::cfg_reg_t'(cfg_index))
        phc_pkg::REG_ON_THRESHOLD:  on_threshold  <= cfg_data[phc_pkg::DELTA_W-1:0];
        phc_pkg::REG_OFF_THRESHOLD: off_threshold <= cfg_data[phc_pkg::DELTA_W-1:0];
        phc_pkg::REG_MIN_OFF_TICKS: min_off_ticks <= cfg_data;
        phc_pkg::REG_MIN_ON_TICKS:  min_on_ticks  <= cfg_data;
        phc_pkg::REG_MAX_ON_TICKS:  max_on_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_func  <= phc_pkg::func_t'(func);
      s1_delta <= temp_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_running  <= 1'b0;
      time_in_state <= '0;
      ever_switched <= 1'b0;
      latest_delta  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (s1_fire) begin
        pump_running  <= pump_running_next;
        time_in_state <= time_in_state_next;
        ever_switched <= ever_switched_next;
        latest_delta  <= latest_delta_next;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
    if (s1_fire) begin
      pump_on <= pump_running_next;
      action  <= action_next;
    end
  end

  a_on_drives_relay: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == phc_pkg::ACT_ON |-> pump_on)
    else $error("switch-on result without relay on");

  a_off_drops_relay: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == phc_pkg::ACT_OFF_TEMP || action == phc_pkg::ACT_OFF_TIMEOUT)
    |-> !pump_on)
    else $error("switch-off result with relay on");

  a_result_tracks_relay: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid && pump_on == pump_running)
    else $error("result relay state differs from held state");

  a_switch_clears_time: assert property (@(posedge clk) disable iff (rst)
    s1_fire && pump_running_next != pump_running |=> time_in_state == '0 && ever_switched)
    else $error("switch did not clear time in state");

  a_stall_needs_full_stage: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled while pipeline can advance");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 4000;
  localparam int REG_COUNT = 5;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 50;
  localparam int PRESSURE_PHASE = 2;
  localparam int PRESSURE_CYCLES = 150;
  localparam int IDX_W = phc_pkg::CFG_IDX_W;
  localparam phc_pkg::delta_t DELTA_MAX = phc_pkg::delta_t'(2047);
  localparam phc_pkg::delta_t DELTA_MIN = phc_pkg::delta_t'(-2048);
  localparam phc_pkg::ticks_t TICKS_MAX = '1;

  typedef struct packed {
    logic             pump_on;
    phc_pkg::action_t action;
  } relay_result_t;

  class pump_scoreboard;
    phc_pkg::delta_t on_thr;
    phc_pkg::delta_t off_thr;
    phc_pkg::ticks_t min_off;
    phc_pkg::ticks_t min_on;
    phc_pkg::ticks_t max_on;
    logic   pump_running;
    logic   ever_switched;
    phc_pkg::ticks_t time_in_state;
    phc_pkg::delta_t latest_delta;
    relay_result_t relay_expect_q[$];
    int mismatches;
    int results_seen;

    function new();
      on_thr = phc_pkg::ON_THRESHOLD_RST;
      off_thr = phc_pkg::OFF_THRESHOLD_RST;
      min_off = phc_pkg::MIN_OFF_TICKS_RST;
      min_on = phc_pkg::MIN_ON_TICKS_RST;
      max_on = phc_pkg::MAX_ON_TICKS_RST;
      pump_running = 1'b0;
      ever_switched = 1'b0;
      time_in_state = '0;
      latest_delta = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_config(phc_pkg::delta_t on_t, phc_pkg::delta_t off_t,
                             phc_pkg::ticks_t off_min, phc_pkg::ticks_t on_min,
                             phc_pkg::ticks_t on_max);
      on_thr = on_t;
      off_thr = off_t;
      min_off = off_min;
      min_on = on_min;
      max_on = on_max;
    endfunction

    function void switch_relay(logic on);
      pump_running = on;
      time_in_state = '0;
      ever_switched = 1'b1;
    endfunction

    function void note_event(phc_pkg::func_t f, phc_pkg::delta_t d);
      relay_result_t r;
      r.action = phc_pkg::ACT_NONE;
      case (f)
        phc_pkg::FUNC_FLOW: begin
          if (latest_delta >= on_thr && !pump_running &&
              (time_in_state >= min_off || !ever_switched)) begin
            switch_relay(1'b1);
            r.action = phc_pkg::ACT_ON;
          end
        end
        phc_pkg::FUNC_TEMP: begin
          latest_delta = d;
          if (d <= off_thr && pump_running && time_in_state >= min_on) begin
            switch_relay(1'b0);
            r.action = phc_pkg::ACT_OFF_TEMP;
          end
        end
        phc_pkg::FUNC_TICK: begin
          if (time_in_state != TICKS_MAX) time_in_state++;
          if (pump_running && time_in_state >= max_on) begin
            switch_relay(1'b0);
            r.action = phc_pkg::ACT_OFF_TIMEOUT;
          end
        end
        default: ;
      endcase
      r.pump_on = pump_running;
      relay_expect_q.push_back(r);
    endfunction

    function void check_result(logic got_on, phc_pkg::action_t got_act);
      relay_result_t want;
      results_seen++;
      if (relay_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with nothing expected: pump_on %0b action %0d",
                   results_seen, got_on, got_act);
      end else begin
        want = relay_expect_q.pop_front();
        if (got_on !== want.pump_on || got_act !== want.action) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected pump_on %0b action %0d, got pump_on %0b action %0d",
                     results_seen, want.pump_on, want.action, got_on, got_act);
        end
      end
    endfunction

    function int pending();
      return relay_expect_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  phc_pkg::func_t func;
  phc_pkg::delta_t temp_delta;
  logic out_valid;
  logic out_stall;
  logic pump_on;
  logic [1:0] action;
  logic cfg_wr_en;
  logic [IDX_W-1:0] cfg_index;
  phc_pkg::ticks_t cfg_data;

  pump_scoreboard sb;
  int sender_pace = 1;
  int receiver_pace = 1;
  int stall_burst = 0;
  int quiet_cycles = 0;

  pump_hysteresis_controller dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .temp_delta(temp_delta),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pump_on(pump_on),
    .action(action),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_gap(int pace);
    if (pace == 0) return 0;
    if (pace == 1 && $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  task automatic send(phc_pkg::func_t f, phc_pkg::delta_t d);
    int gap;
    gap = draw_gap(sender_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    temp_delta <= d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random();
    int pick;
    int r;
    phc_pkg::func_t f;
    phc_pkg::delta_t d;
    pick = $urandom_range(0, 99);
    if (pick < 40) f = phc_pkg::FUNC_TICK;
    else if (pick < 65) f = phc_pkg::FUNC_TEMP;
    else if (pick < 90) f = phc_pkg::FUNC_FLOW;
    else f = phc_pkg::FUNC_NONE;
    r = $urandom_range(0, 16);
    case ($urandom_range(0, 4))
      0, 1: d = sb.on_thr + phc_pkg::delta_t'(r - 8);
      2, 3: d = sb.off_thr + phc_pkg::delta_t'(r - 8);
      default: d = phc_pkg::delta_t'($urandom);
    endcase
    send(f, d);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] idx, phc_pkg::ticks_t data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic configure(phc_pkg::delta_t on_t, phc_pkg::delta_t off_t,
                           phc_pkg::ticks_t off_min, phc_pkg::ticks_t on_min,
                           phc_pkg::ticks_t on_max);
    cfg_write(IDX_W'($urandom_range(REG_COUNT, (1 << IDX_W) - 1)),
              phc_pkg::ticks_t'($urandom));
    cfg_write(phc_pkg::REG_ON_THRESHOLD, phc_pkg::ticks_t'(on_t));
    cfg_write(phc_pkg::REG_OFF_THRESHOLD, phc_pkg::ticks_t'(off_t));
    cfg_write(phc_pkg::REG_MIN_OFF_TICKS, off_min);
    cfg_write(phc_pkg::REG_MIN_ON_TICKS, on_min);
    cfg_write(phc_pkg::REG_MAX_ON_TICKS, on_max);
    cfg_wr_en <= 1'b0;
    sb.set_config(on_t, off_t, off_min, on_min, on_max);
  endtask

  task automatic configure_random();
    phc_pkg::delta_t on_t;
    phc_pkg::delta_t off_t;
    phc_pkg::ticks_t off_min;
    phc_pkg::ticks_t on_min;
    phc_pkg::ticks_t on_max;
    on_t = phc_pkg::delta_t'(int'($urandom_range(0, 64)) - 32);
    off_t = phc_pkg::delta_t'(int'($urandom_range(0, 64)) - 32);
    off_min = phc_pkg::ticks_t'($urandom_range(0, 10));
    on_min = phc_pkg::ticks_t'($urandom_range(0, 10));
    on_max = phc_pkg::ticks_t'($urandom_range(0, 24));
    if ($urandom_range(0, 5) == 0) on_max = TICKS_MAX;
    if ($urandom_range(0, 7) == 0) off_min = phc_pkg::ticks_t'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      on_t = phc_pkg::delta_t'($urandom);
      off_t = phc_pkg::delta_t'($urandom);
    end
    configure(on_t, off_t, off_min, on_min, on_max);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // receiver: random hold-offs, plus one long burst on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_burst > 0) begin
        n = stall_burst;
        stall_burst = 0;
      end else begin
        n = draw_gap(receiver_pace);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (in_valid && !in_stall) sb.note_event(func, temp_delta);
      if (out_valid && !out_stall) sb.check_result(pump_on, phc_pkg::action_t'(action));
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    func = phc_pkg::FUNC_NONE;
    temp_delta = '0;
    cfg_wr_en = 1'b0;
    cfg_index = phc_pkg::REG_ON_THRESHOLD;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(phc_pkg::FUNC_NONE, DELTA_MAX);
    send(phc_pkg::FUNC_TICK, DELTA_MIN);
    send(phc_pkg::FUNC_FLOW, DELTA_MAX);
    send(phc_pkg::FUNC_TEMP, phc_pkg::ON_THRESHOLD_RST);
    send(phc_pkg::FUNC_TICK, DELTA_MIN);
    send(phc_pkg::FUNC_FLOW, '0);
    send(phc_pkg::FUNC_TEMP, phc_pkg::OFF_THRESHOLD_RST);
    send(phc_pkg::FUNC_FLOW, DELTA_MAX);
    drain();

    configure(DELTA_MAX, DELTA_MIN, '0, '0, '0);
    send(phc_pkg::FUNC_TEMP, DELTA_MAX);
    send(phc_pkg::FUNC_TEMP, DELTA_MIN);
    send(phc_pkg::FUNC_FLOW, DELTA_MAX);
    send(phc_pkg::FUNC_TEMP, DELTA_MAX);
    send(phc_pkg::FUNC_FLOW, DELTA_MIN);
    send(phc_pkg::FUNC_TICK, '0);
    send(phc_pkg::FUNC_NONE, DELTA_MIN);
    drain();

    configure(DELTA_MIN, DELTA_MAX, phc_pkg::ticks_t'(3), phc_pkg::ticks_t'(2), TICKS_MAX);
    send(phc_pkg::FUNC_FLOW, DELTA_MAX);
    repeat (3) send(phc_pkg::FUNC_TICK, DELTA_MAX);
    send(phc_pkg::FUNC_FLOW, DELTA_MIN);
    send(phc_pkg::FUNC_TEMP, '0);
    repeat (2) send(phc_pkg::FUNC_TICK, DELTA_MIN);
    send(phc_pkg::FUNC_TEMP, '0);
    drain();

    // drive ticks and flows back to back at full rate
    sender_pace = 0;
    receiver_pace = 0;
    configure(DELTA_MIN, DELTA_MIN, TICKS_MAX, '0, TICKS_MAX);
    repeat (16) send(phc_pkg::FUNC_TICK, phc_pkg::delta_t'($urandom));
    send(phc_pkg::FUNC_FLOW, DELTA_MAX);
    repeat (6) send(phc_pkg::FUNC_TICK, phc_pkg::delta_t'($urandom));
    send(phc_pkg::FUNC_FLOW, DELTA_MIN);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      configure_random();
      sender_pace = $urandom_range(0, 2);
      receiver_pace = $urandom_range(0, 2);
      if (p == PRESSURE_PHASE) begin
        sender_pace = 0;
        stall_burst = PRESSURE_CYCLES;
      end
      repeat (PHASE_ITEMS) send_random();
      drain();
    end

    repeat (6) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== pump_hysteresis_controller.f =====
src/phc_pkg.sv
src/pump_hysteresis_controller.sv
tb/tb.sv
